>>> rtl/tspb_pkg.sv
// Shared constants and types for the transport stream PID boost and stuffing replacement unit.
package tspb_pkg;

  // Packet geometry
  localparam int unsigned WORDS_PER_PACKET = 47;
  localparam int unsigned POS_W            = 6;

  // Header and adaptation field bytes
  localparam logic [12:0] NULL_PID       = 13'h1FFF;
  localparam logic [7:0]  SYNC_BYTE      = 8'h47;
  localparam logic [7:0]  AF_ONLY_FLAGS  = 8'h20;
  localparam logic [7:0]  AF_LENGTH      = 8'd183;
  localparam logic [7:0]  AF_EMPTY_FLAGS = 8'h00;
  localparam logic [7:0]  STUFF_BYTE     = 8'hFF;
  localparam logic [15:0] PENDING_MAX    = 16'hFFFF;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_TARGET_PID  = 2'd0;
  localparam cfg_index_t CFG_ADD_PACKETS = 2'd1;
  localparam cfg_index_t CFG_IN_PACKETS  = 2'd2;

  // One result word with its sideband flags
  typedef struct packed {
    logic        overflow;
    logic        replaced;
    logic        first;
    logic [31:0] word;
  } ts_result_t;

endpackage

>>> rtl/tspb_rewrite.sv
// Per-word packet classification, period counting and null packet rewriting.
module tspb_rewrite
  import tspb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [31:0] data_word,
  input  logic        first_word,
  output ts_result_t  result
);

  logic [12:0]      target_pid;
  logic [7:0]       add_packets;
  logic [15:0]      in_packets;

  logic [15:0]      period_countdown, period_countdown_next;
  logic [15:0]      pending_adds, pending_adds_next;
  logic [3:0]       last_continuity, last_continuity_next;
  logic             rewriting, rewriting_next;
  logic [POS_W-1:0] word_position, word_position_next;

  logic [12:0]      pid;
  logic [15:0]      cd_loaded;
  logic [16:0]      sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_pid  <= 13'h1FFF;
      add_packets <= 8'd1;
      in_packets  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_PID:  target_pid  <= cfg_wdata[12:0];
        CFG_ADD_PACKETS: add_packets <= cfg_wdata[7:0];
        CFG_IN_PACKETS:  in_packets  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pid       = data_word[20:8];
  assign cd_loaded = (period_countdown == 16'd0) ? in_packets : period_countdown;
  assign sum       = {1'b0, pending_adds} + {9'd0, add_packets};

  // Work out the result word and the state after this word
  always_comb begin
    period_countdown_next = period_countdown;
    pending_adds_next     = pending_adds;
    last_continuity_next  = last_continuity;
    rewriting_next        = rewriting;
    word_position_next    = word_position;
    result.word           = data_word;
    result.first          = first_word;
    result.replaced       = 1'b0;
    result.overflow       = 1'b0;
    if (first_word) begin
      word_position_next = '0;
      rewriting_next     = 1'b0;
      if (pid == target_pid) begin
        if (period_countdown == 16'd0) begin
          result.overflow   = (pending_adds != 16'd0);
          pending_adds_next = sum[16] ? PENDING_MAX : sum[15:0];
        end
        period_countdown_next = (cd_loaded != 16'd0) ? cd_loaded - 16'd1 : 16'd0;
        last_continuity_next  = data_word[3:0];
      end else if (pid == NULL_PID && pending_adds != 16'd0) begin
        pending_adds_next = pending_adds - 16'd1;
        rewriting_next    = 1'b1;
        result.replaced   = 1'b1;
        result.word       = {SYNC_BYTE, 3'b000, target_pid, AF_ONLY_FLAGS[7:4],
                             last_continuity};
      end
    end else begin
      if (word_position < POS_W'(WORDS_PER_PACKET)) begin
        word_position_next = word_position + POS_W'(1);
      end
      if (rewriting && word_position_next < POS_W'(WORDS_PER_PACKET)) begin
        result.replaced = 1'b1;
        if (word_position_next == POS_W'(1)) begin
          result.word = {AF_LENGTH, AF_EMPTY_FLAGS, STUFF_BYTE, STUFF_BYTE};
        end else begin
          result.word = {4{STUFF_BYTE}};
        end
      end else begin
        rewriting_next = 1'b0;
      end
    end
  end

  // Advance the stream state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      period_countdown <= '0;
      pending_adds     <= '0;
      last_continuity  <= '0;
      rewriting        <= 1'b0;
      word_position    <= '0;
    end else if (accept) begin
      period_countdown <= period_countdown_next;
      pending_adds     <= pending_adds_next;
      last_continuity  <= last_continuity_next;
      rewriting        <= rewriting_next;
      word_position    <= word_position_next;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pending_adds) && $stable(word_position) && $stable(rewriting))
    else $error("stream state moved without a transfer");
  a_pending_only_on_header: assert property (@(posedge clk) disable iff (rst)
    accept && !first_word |=> $stable(pending_adds))
    else $error("pending count changed on a body word");
  a_rewrite_consumes: assert property (@(posedge clk) disable iff (rst)
    accept && first_word && result.replaced |=> pending_adds == $past(pending_adds) - 16'd1)
    else $error("rewritten header did not consume a pending insertion");
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    word_position <= POS_W'(WORDS_PER_PACKET))
    else $error("word position beyond packet length");
`endif

endmodule

>>> rtl/tspb_out_buf.sv
// Two-entry output buffer that parts the input and output handshakes.
module tspb_out_buf
  import tspb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ts_result_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ts_result_t out_data
);

  ts_result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  // Store an incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("output buffer overfilled");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("output buffer lost a transfer");
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("output buffer pointers disagree with fill level");
`endif

endmodule

>>> rtl/ts_pid_boost_stuffing_replace_unit.sv
// Results are registered in the output buffer. Throughput: one 32-bit word per cycle
// unless the buffer is full; all packet logic sits between the input port and a two-entry
// output buffer, so s_tready stays high while one result waits.
// Reset (rst, synchronous): clears period, pending, continuity and position state,
// loads register defaults (target PID 8191, add 1, period 1) and empties the buffer.
// Top level: transport stream PID boost by rewriting null stuffing packets.
module ts_pid_boost_stuffing_replace_unit
  import tspb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_word
  input  logic [0:0]  s_tuser,   // [0] first_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] out_word
  output logic [2:0]  m_tuser,   // [0] out_first, [1] replaced, [2] overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ts_result_t result;
  ts_result_t out_data;
  logic       accept;

  assign accept = s_tvalid && s_tready;

  // Classify and rewrite each word
  tspb_rewrite u_rewrite (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_word  (s_tdata),
    .first_word (s_tuser[0]),
    .result     (result)
  );

  // Hold results for the master side
  tspb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.word;
  assign m_tuser = {out_data.overflow, out_data.replaced, out_data.first};

endmodule
